>>> design/gdd_pkg.sv
// Shared types and constants for the Gregorian day difference block.
// Holds the control word layout, the microprogram and the month table.
// No dependencies.
package gdd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DIFF_W  = 23;
    localparam int ACC_W   = 24;
    localparam int TERM_W  = 23;
    localparam int STEP_W  = 4;
    localparam int CFG_W   = 14;
    localparam int CIDX_W  = 2;
    localparam int QY_W    = 8;
    localparam int DIVX_W  = 15;
    localparam int RECIP_W = 20;
    localparam int RECIP_SHIFT = 24;
    localparam int DIVQ_W  = 11;

    // Multiply-and-shift reciprocal of 25, exact for operands below 2**24 / 9.
    localparam logic [RECIP_W-1:0] RECIP_25 = 20'd671089;

    localparam logic [YEAR_W-1:0]  REF_YEAR_RST  = 14'd2015;
    localparam logic [MONTH_W-1:0] REF_MONTH_RST = 4'd4;
    localparam logic [DAY_W-1:0]   REF_DAY_RST   = 5'd8;

    localparam logic [CIDX_W-1:0] CFG_REF_YEAR  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_REF_MONTH = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_REF_DAY   = 2'd2;

    localparam logic [2:0] TERM_NONE  = 3'd0;
    localparam logic [2:0] TERM_Y365  = 3'd1;
    localparam logic [2:0] TERM_Q4    = 3'd2;
    localparam logic [2:0] TERM_Q100  = 3'd3;
    localparam logic [2:0] TERM_Q400  = 3'd4;
    localparam logic [2:0] TERM_MONTH = 3'd5;
    localparam logic [2:0] TERM_DAY   = 3'd6;

    localparam logic [1:0] ACC_NOP = 2'd0;
    localparam logic [1:0] ACC_CLR = 2'd1;
    localparam logic [1:0] ACC_ADD = 2'd2;
    localparam logic [1:0] ACC_SUB = 2'd3;

    localparam logic [1:0] JMP_NEXT     = 2'd0;
    localparam logic [1:0] JMP_WAIT_IN  = 2'd1;
    localparam logic [1:0] JMP_WAIT_OUT = 2'd2;

    localparam logic SRC_IN  = 1'b0;
    localparam logic SRC_REF = 1'b1;

    typedef struct packed {
        logic              src_ref;
        logic [2:0]        term_sel;
        logic [1:0]        acc_op;
        logic              ld_q;
        logic              ld_leap;
        logic              emit;
        logic [1:0]        jmp;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    // Days in the year before the first of month m, February taken as 28 days.
    function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd365;
        endcase
        return d;
    endfunction

    // Steps 1 to 12 each load a term; steps 2 to 13 each add or subtract the term loaded by the step before.
    function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
        ctrl_word_t cw;
        case (step)
            4'd0:    cw = '{SRC_IN,  TERM_NONE,  ACC_CLR, 1'b0, 1'b0, 1'b0, JMP_WAIT_IN,  4'd0};
            4'd1:    cw = '{SRC_IN,  TERM_Y365,  ACC_NOP, 1'b1, 1'b0, 1'b0, JMP_NEXT,     4'd0};
            4'd2:    cw = '{SRC_IN,  TERM_Q4,    ACC_ADD, 1'b0, 1'b1, 1'b0, JMP_NEXT,     4'd0};
            4'd3:    cw = '{SRC_IN,  TERM_Q100,  ACC_ADD, 1'b0, 1'b0, 1'b0, JMP_NEXT,     4'd0};
            4'd4:    cw = '{SRC_IN,  TERM_Q400,  ACC_SUB, 1'b0, 1'b0, 1'b0, JMP_NEXT,     4'd0};
            4'd5:    cw = '{SRC_IN,  TERM_MONTH, ACC_ADD, 1'b0, 1'b0, 1'b0, JMP_NEXT,     4'd0};
            4'd6:    cw = '{SRC_IN,  TERM_DAY,   ACC_ADD, 1'b0, 1'b0, 1'b0, JMP_NEXT,     4'd0};
            4'd7:    cw = '{SRC_REF, TERM_Y365,  ACC_ADD, 1'b1, 1'b0, 1'b0, JMP_NEXT,     4'd0};
            4'd8:    cw = '{SRC_REF, TERM_Q4,    ACC_SUB, 1'b0, 1'b1, 1'b0, JMP_NEXT,     4'd0};
            4'd9:    cw = '{SRC_REF, TERM_Q100,  ACC_SUB, 1'b0, 1'b0, 1'b0, JMP_NEXT,     4'd0};
            4'd10:   cw = '{SRC_REF, TERM_Q400,  ACC_ADD, 1'b0, 1'b0, 1'b0, JMP_NEXT,     4'd0};
            4'd11:   cw = '{SRC_REF, TERM_MONTH, ACC_SUB, 1'b0, 1'b0, 1'b0, JMP_NEXT,     4'd0};
            4'd12:   cw = '{SRC_REF, TERM_DAY,   ACC_SUB, 1'b0, 1'b0, 1'b0, JMP_NEXT,     4'd0};
            4'd13:   cw = '{SRC_IN,  TERM_NONE,  ACC_SUB, 1'b0, 1'b0, 1'b0, JMP_NEXT,     4'd0};
            4'd14:   cw = '{SRC_IN,  TERM_NONE,  ACC_NOP, 1'b0, 1'b0, 1'b1, JMP_WAIT_OUT, 4'd0};
            default: cw = '{SRC_IN,  TERM_NONE,  ACC_NOP, 1'b0, 1'b0, 1'b0, JMP_NEXT,     4'd0};
        endcase
        return cw;
    endfunction

endpackage

>>> design/gdd_useq.sv
// Microcode sequencer: step counter, control store and jump logic.
// Depends on gdd_pkg.
module gdd_useq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic                out_free,
    output gdd_pkg::ctrl_word_t ctrl
);
    import gdd_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    assign ctrl = ucode_rom(step_reg);

    always_comb
    begin
        case (ctrl.jmp)
            JMP_NEXT:     step_next = step_reg + 1'b1;
            JMP_WAIT_IN:  step_next = in_fire ? step_reg + 1'b1 : step_reg;
            JMP_WAIT_OUT: step_next = out_free ? ctrl.target : step_reg;
            default:      step_next = ctrl.target;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

>>> design/gdd_datapath.sv
// Datapath: date and reference registers, term unit, accumulator and output register.
// Driven by the control word from gdd_useq; depends on gdd_pkg.
module gdd_datapath #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  gdd_pkg::ctrl_word_t                 ctrl,
    input  logic                                in_fire,
    input  logic [gdd_pkg::YEAR_W-1:0]          in_year,
    input  logic [gdd_pkg::MONTH_W-1:0]         in_month,
    input  logic [gdd_pkg::DAY_W-1:0]           in_day,
    input  logic                                cfg_we,
    input  logic [gdd_pkg::CIDX_W-1:0]          cfg_index,
    input  logic [gdd_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                out_ready,
    output logic                                out_free,
    output logic                                out_valid,
    output logic signed [gdd_pkg::DIFF_W-1:0]   day_difference
);
    import gdd_pkg::*;

    localparam logic [16:0] MAX_Y = 17'(MAX_YEAR);

    logic [YEAR_W-1:0]  in_year_reg;
    logic [MONTH_W-1:0] in_month_reg;
    logic [DAY_W-1:0]   in_day_reg;
    logic [YEAR_W-1:0]  ref_year_reg;
    logic [MONTH_W-1:0] ref_month_reg;
    logic [DAY_W-1:0]   ref_day_reg;
    logic [TERM_W-1:0]  term_reg;
    logic [TERM_W-1:0]  term_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic [QY_W-1:0]    qy_reg;
    logic               leap_reg;
    logic               leap_next;
    logic               out_valid_reg;
    logic [DIFF_W-1:0]  diff_reg;

    logic [YEAR_W-1:0]  sel_year;
    logic [MONTH_W-1:0] sel_month;
    logic [DAY_W-1:0]   sel_day;
    logic [YEAR_W-1:0]  ys;
    logic [TERM_W-1:0]  y365;
    logic [14:0]        s3;
    logic [14:0]        s99;
    logic [14:0]        s399;
    logic [DIVX_W-1:0]  div_x;
    logic [DIVX_W+RECIP_W-1:0] div_prod;
    logic [DIVQ_W-1:0]  div_q;
    logic [11:0]        qy25;
    logic               div100;
    logic [8:0]         month_days;

    assign sel_year  = ctrl.src_ref ? ref_year_reg  : in_year_reg;
    assign sel_month = ctrl.src_ref ? ref_month_reg : in_month_reg;
    assign sel_day   = ctrl.src_ref ? ref_day_reg   : in_day_reg;

    assign ys   = ({3'b000, sel_year} > MAX_Y) ? MAX_Y[YEAR_W-1:0] : sel_year;
    assign y365 = {9'd0, ys} * 23'd365;
    assign s3   = {1'b0, ys} + 15'd3;
    assign s99  = {1'b0, ys} + 15'd99;
    assign s399 = {1'b0, ys} + 15'd399;

    always_comb
    begin
        case (ctrl.term_sel)
            TERM_Q100: div_x = {2'b00, s99[14:2]};
            TERM_Q400: div_x = {4'b0000, s399[14:4]};
            default:   div_x = {3'b000, ys[YEAR_W-1:2]};
        endcase
    end

    assign div_prod = {{RECIP_W{1'b0}}, div_x} * {{DIVX_W{1'b0}}, RECIP_25};
    assign div_q    = div_prod[RECIP_SHIFT+DIVQ_W-1:RECIP_SHIFT];

    // A year is a multiple of 100 when its quarter equals 25 times its quotient by 100.
    assign qy25      = {qy_reg, 4'b0000} + {1'b0, qy_reg, 3'b000} + {4'b0000, qy_reg};
    assign div100    = (ys[1:0] == 2'b00) && (ys[YEAR_W-1:2] == qy25);
    assign leap_next = (ys[1:0] == 2'b00) && (!div100 || (qy_reg[1:0] == 2'b00));

    assign month_days = cum_days(sel_month)
                      + {8'd0, leap_reg && (sel_month > 4'd2)};

    always_comb
    begin
        case (ctrl.term_sel)
            TERM_Y365:  term_next = y365;
            TERM_Q4:    term_next = {10'd0, s3[14:2]};
            TERM_Q100:  term_next = {12'd0, div_q};
            TERM_Q400:  term_next = {12'd0, div_q};
            TERM_MONTH: term_next = {14'd0, month_days};
            TERM_DAY:   term_next = {18'd0, sel_day};
            default:    term_next = '0;
        endcase
    end

    always_comb
    begin
        case (ctrl.acc_op)
            ACC_CLR: acc_next = '0;
            ACC_ADD: acc_next = acc_reg + $signed({1'b0, term_reg});
            ACC_SUB: acc_next = acc_reg - $signed({1'b0, term_reg});
            default: acc_next = acc_reg;
        endcase
    end

    assign out_free       = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign day_difference = $signed(diff_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_year_reg  <= REF_YEAR_RST;
            ref_month_reg <= REF_MONTH_RST;
            ref_day_reg   <= REF_DAY_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_REF_YEAR:  ref_year_reg  <= cfg_data[YEAR_W-1:0];
                    CFG_REF_MONTH: ref_month_reg <= cfg_data[MONTH_W-1:0];
                    CFG_REF_DAY:   ref_day_reg   <= cfg_data[DAY_W-1:0];
                    default:       ;
                endcase
            end
            if (ctrl.emit && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_year_reg  <= in_year;
            in_month_reg <= in_month;
            in_day_reg   <= in_day;
        end
        term_reg <= term_next;
        acc_reg  <= acc_next;
        if (ctrl.ld_q)
        begin
            qy_reg <= div_q[QY_W-1:0];
        end
        if (ctrl.ld_leap)
        begin
            leap_reg <= leap_next;
        end
        if (ctrl.emit && out_free)
        begin
            diff_reg <= acc_reg[DIFF_W-1:0];
        end
    end

endmodule

>>> design/gregorian_day_difference.sv
// Top level of the Gregorian day difference block.
// Instantiates gdd_useq and gdd_datapath; depends on gdd_pkg.
//
// Each input beat carries a date (in_year, in_month, in_day) on a valid/ready
// channel. The block returns one output beat, day_difference, holding the
// signed number of days from the reference date to the input date.
// The reference date is written through cfg_we, cfg_index and cfg_data:
// index 0 is the year, 1 the month and 2 the day; other indexes are ignored.
// Writes should only be made while no beat is in flight.
// A short microprogram of fifteen steps computes each date's day number from
// year length, leap-year counts, month offset and day, then subtracts.
// Once an input beat is accepted the sequencer runs through the program to
// its final step, which loads the output register; only then does it return to
// its waiting step, so a new input beat is not accepted before the last is done.
// The result sits in an output register, so a stalled receiver only holds
// the sequencer at its final step while a following result is ready.
// Reset returns the sequencer to its waiting step, empties the output register
// and sets the reference date to 8 April 2015.
module gregorian_day_difference #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [gdd_pkg::YEAR_W-1:0]          in_year,
    input  logic [gdd_pkg::MONTH_W-1:0]         in_month,
    input  logic [gdd_pkg::DAY_W-1:0]           in_day,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [gdd_pkg::DIFF_W-1:0]   day_difference,
    input  logic                                cfg_we,
    input  logic [gdd_pkg::CIDX_W-1:0]          cfg_index,
    input  logic [gdd_pkg::CFG_W-1:0]           cfg_data
);
    import gdd_pkg::*;

    ctrl_word_t ctrl;
    logic       in_fire;
    logic       out_free;

    assign in_ready = (ctrl.jmp == JMP_WAIT_IN);
    assign in_fire  = in_valid && in_ready;

    gdd_useq u_useq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    gdd_datapath #(
        .MAX_YEAR (MAX_YEAR)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .in_fire        (in_fire),
        .in_year        (in_year),
        .in_month       (in_month),
        .in_day         (in_day),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_ready      (out_ready),
        .out_free       (out_free),
        .out_valid      (out_valid),
        .day_difference (day_difference)
    );

endmodule

>>> tb/gdd_tb_pkg.sv
// Scoreboard for the Gregorian day difference testbench: a day-number predictor
// and the queue of day spans still awaited from the block.
// Depends on gdd_pkg for the field widths, register indexes and reset values.
package gdd_tb_pkg;

    import gdd_pkg::*;

    localparam int unsigned MAX_YEAR = 9999;
    localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int unsigned DAYS_IN_MONTH [16] = '{
        0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31, 0, 0, 0
    };

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    class day_span_scoreboard;

        date_t             reference;
        logic [DIFF_W-1:0] expected_spans [$];
        int                mismatches;

        function new();
            reference.year  = REF_YEAR_RST;
            reference.month = REF_MONTH_RST;
            reference.day   = REF_DAY_RST;
            mismatches      = 0;
        endfunction

        function void write_reg(logic [CIDX_W-1:0] index, logic [CFG_W-1:0] data);
            case (index)
                CFG_REF_YEAR:  reference.year  = data[YEAR_W-1:0];
                CFG_REF_MONTH: reference.month = data[MONTH_W-1:0];
                CFG_REF_DAY:   reference.day   = data[DAY_W-1:0];
                default:       ;
            endcase
        endfunction

        function bit is_leap(int unsigned y);
            return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        endfunction

        // Days counted from 1 January of year 0, with the day field added as it stands.
        function longint day_number(date_t dt);
            int unsigned y;
            int unsigned i;
            longint      days;
            y = dt.year;
            if (y > MAX_YEAR)
                y = MAX_YEAR;
            days = y * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
            for (i = 1; i < dt.month; i++)
            begin
                days += DAYS_IN_MONTH[i];
                if (i == 2 && is_leap(y))
                    days += 1;
            end
            days += dt.day;
            return days;
        endfunction

        function void note_date(date_t dt);
            longint span;
            span = day_number(dt) - day_number(reference);
            expected_spans.push_back(span[DIFF_W-1:0]);
        endfunction

        function int pending();
            return expected_spans.size();
        endfunction

        task report_mismatch(string what);
            $display("day span mismatch: %s", what);
            mismatches++;
        endtask

        task check_span(logic [DIFF_W-1:0] got);
            logic [DIFF_W-1:0] want;
            if (expected_spans.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat with %0d", $signed(got)));
            end
            else
            begin
                want = expected_spans.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("day_difference %0d, expected %0d",
                                              $signed(got), $signed(want)));
            end
        endtask

        task flush_check();
            if (expected_spans.size() != 0)
                report_mismatch($sformatf("%0d results never arrived",
                                          expected_spans.size()));
        endtask

    endclass

endpackage

>>> tb/tb_gregorian_day_difference.sv
// Top-level testbench for gregorian_day_difference: directed and random dates
// against several reference dates, with random gaps on both channels.
// Depends on gdd_pkg, gdd_tb_pkg and the block itself.
module tb_gregorian_day_difference;

    import gdd_pkg::*;
    import gdd_tb_pkg::*;

    localparam int STALL_LIMIT     = 1000;
    localparam int PHASES          = 8;
    localparam int DATES_PER_PHASE = 10;
    localparam int DIRECTED_COUNT  = 22;

    localparam date_t DIRECTED_DATES [DIRECTED_COUNT] = '{
        '{14'd2015,  4'd4,  5'd8},
        '{14'd2015,  4'd4,  5'd9},
        '{14'd2015,  4'd4,  5'd7},
        '{14'd1,     4'd1,  5'd1},
        '{14'd9999,  4'd12, 5'd31},
        '{14'd0,     4'd1,  5'd1},
        '{14'd0,     4'd0,  5'd0},
        '{14'd16383, 4'd15, 5'd31},
        '{14'd10000, 4'd1,  5'd1},
        '{14'd2000,  4'd2,  5'd29},
        '{14'd2000,  4'd3,  5'd1},
        '{14'd1900,  4'd2,  5'd29},
        '{14'd1900,  4'd3,  5'd1},
        '{14'd2100,  4'd3,  5'd1},
        '{14'd2400,  4'd3,  5'd1},
        '{14'd2015,  4'd2,  5'd31},
        '{14'd2015,  4'd0,  5'd5},
        '{14'd2015,  4'd13, 5'd1},
        '{14'd2015,  4'd15, 5'd31},
        '{14'd2015,  4'd4,  5'd0},
        '{14'd2015,  4'd6,  5'd31},
        '{14'd2016,  4'd12, 5'd31}
    };

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [YEAR_W-1:0]        in_year;
    logic [MONTH_W-1:0]       in_month;
    logic [DAY_W-1:0]         in_day;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DIFF_W-1:0] day_difference;
    logic                     cfg_we;
    logic [CIDX_W-1:0]        cfg_index;
    logic [CFG_W-1:0]         cfg_data;

    day_span_scoreboard spans = new();
    int                 send_idle_pct = 0;
    int                 stall_pct = 0;
    int                 quiet_cycles = 0;

    gregorian_day_difference #(
        .MAX_YEAR(MAX_YEAR)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_year(in_year),
        .in_month(in_month),
        .in_day(in_day),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .day_difference(day_difference),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(negedge clk)
    begin
        out_ready = ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                spans.check_span(day_difference);
            if (in_valid && in_ready)
                spans.note_date('{in_year, in_month, in_day});
            if ((out_valid && out_ready) || (in_valid && in_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin : watchdog
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    task automatic write_reg(logic [CIDX_W-1:0] index, logic [CFG_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        spans.write_reg(index, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_reference(date_t r);
        write_reg(CFG_REF_YEAR, CFG_W'(r.year));
        write_reg(CFG_REF_MONTH, CFG_W'(r.month));
        write_reg(CFG_REF_DAY, CFG_W'(r.day));
    endtask

    task automatic send_date(date_t dt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_year  = dt.year;
        in_month = dt.month;
        in_day   = dt.day;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (spans.pending() != 0)
            @(posedge clk);
        repeat (16) @(negedge clk);
    endtask

    // Most beats carry well-formed dates; some sit close to the reference and
    // the rest use the full width of every field.
    function automatic date_t random_date();
        date_t       dt;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            dt.year  = YEAR_W'($urandom_range(MAX_YEAR, 1));
            dt.month = MONTH_W'($urandom_range(12, 1));
            dt.day   = DAY_W'($urandom_range(28, 1));
        end
        else if (pick < 85)
        begin
            dt.year  = spans.reference.year + YEAR_W'($urandom_range(4)) - YEAR_W'(2);
            dt.month = MONTH_W'($urandom_range(12, 1));
            dt.day   = DAY_W'($urandom_range(31, 1));
        end
        else
        begin
            dt.year  = YEAR_W'($urandom_range(16383));
            dt.month = MONTH_W'($urandom_range(15));
            dt.day   = DAY_W'($urandom_range(31));
        end
        return dt;
    endfunction

    task automatic configure_phase(int phase);
        date_t r;
        case (phase)
            0: r = '{14'd1, 4'd1, 5'd1};
            1: r = '{YEAR_W'(MAX_YEAR), 4'd12, 5'd31};
            2: r = '{14'd0, 4'd0, 5'd0};
            3: r = '{14'd16383, 4'd15, 5'd31};
            default:
            begin
                r.year  = YEAR_W'($urandom_range(MAX_YEAR, 1));
                r.month = MONTH_W'($urandom_range(12, 1));
                r.day   = DAY_W'($urandom_range(28, 1));
            end
        endcase
        set_reference(r);
        if (phase == 3)
            write_reg(CFG_UNUSED, CFG_W'($urandom()));
    endtask

    initial
    begin
        int phase;
        int k;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_year   = '0;
        in_month  = '0;
        in_day    = '0;
        out_ready = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (k = 0; k < DIRECTED_COUNT; k++)
            send_date(DIRECTED_DATES[k]);
        drain();

        for (phase = 0; phase < PHASES; phase++)
        begin
            configure_phase(phase);
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 75; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 75; end
                default: begin send_idle_pct = 36; stall_pct = 36; end
            endcase
            for (k = 0; k < DATES_PER_PHASE; k++)
                send_date(random_date());
            drain();
        end

        spans.flush_check();
        if (spans.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
design/gdd_pkg.sv
design/gdd_useq.sv
design/gdd_datapath.sv
design/gregorian_day_difference.sv
tb/gdd_tb_pkg.sv
tb/tb_gregorian_day_difference.sv
